// ===== rtl/rle8d_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLE8 run decoder package
// Shared constants and types of the 8-bit run-length bitmap run decoder.
// ----------------------------------------------------------------------------
package rle8d_pkg;

   localparam int unsigned MAX_LINE_BYTES = 16384;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STRIDE_W = 15;
   localparam int unsigned COUNT_W  = 24;
   localparam int unsigned LEN_W    = 15;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_TOTAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_TOTAL = 2'd2;

   // Reset values of the registers.
   localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 15'd4;
   localparam logic [COUNT_W-1:0]  OUT_TOTAL_RESET = 24'd1;
   localparam logic [COUNT_W-1:0]  SRC_TOTAL_RESET = 24'd1;

   // Depth of the queue between the decoder and the output side.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [STRIDE_W-1:0] line_stride;
      logic [COUNT_W-1:0]  output_total;
      logic [COUNT_W-1:0]  source_total;
   } cfg_type;

   typedef struct packed {
      logic                finished;
      logic [LEN_W-1:0]    run_length;
      logic [BYTE_W-1:0]   fill_value;
   } run_type;

endpackage
`default_nettype wire

// ===== rtl/rle8d_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLE8 run decoder front end
// Takes one compressed byte per cycle while byte_accept is high, tracks
// the escape state and counters and produces at most one run per byte.
// ----------------------------------------------------------------------------
module rle8d_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rle8d_pkg::cfg_type              cfg,
   input  wire logic                            byte_accept,
   input  wire logic [rle8d_pkg::BYTE_W-1:0]    src_byte,
   input  wire logic                            start_image,
   output      logic                            run_push,
   output      rle8d_pkg::run_type              run_data
);

   typedef enum logic [2:0] {
      PH_COUNT   = 3'd0,
      PH_VALUE   = 3'd1,
      PH_LITERAL = 3'd2,
      PH_PAD     = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   localparam logic [rle8d_pkg::COUNT_W-1:0] MAX_LINE =
      rle8d_pkg::COUNT_W'(rle8d_pkg::MAX_LINE_BYTES);

   phase_type                          phase_ff,  phase_in;
   logic [rle8d_pkg::BYTE_W-1:0]       held_ff,   held_in;
   logic [rle8d_pkg::BYTE_W-1:0]       lit_ff,    lit_in;
   logic                               pad_ff,    pad_in;
   logic [rle8d_pkg::COUNT_W-1:0]      offset_ff, offset_in;
   logic [rle8d_pkg::COUNT_W-1:0]      outl_ff,   outl_in;
   logic [rle8d_pkg::COUNT_W-1:0]      srcl_ff,   srcl_in;

   // State as seen by this byte, after an optional restart.
   phase_type                          ph;
   logic [rle8d_pkg::BYTE_W-1:0]       held, lit;
   logic                               pad;
   logic [rle8d_pkg::COUNT_W-1:0]      offset, outl, srcl, srcl_dec;
   logic [rle8d_pkg::COUNT_W-1:0]      b_wide, n_wide, stride_wide, fill_wide, outl_sub;
   logic                               spent_after;
   logic                               emit;
   rle8d_pkg::run_type                 run;

   always_comb begin
      ph       = start_image ? PH_COUNT : phase_ff;
      held     = start_image ? '0 : held_ff;
      lit      = start_image ? '0 : lit_ff;
      pad      = start_image ? 1'b0 : pad_ff;
      offset   = start_image ? '0 : offset_ff;
      outl     = start_image ? cfg.output_total : outl_ff;
      srcl     = start_image ? cfg.source_total : srcl_ff;
      srcl_dec = srcl - 1'b1;
      b_wide   = {{(rle8d_pkg::COUNT_W-rle8d_pkg::BYTE_W){1'b0}}, src_byte};

      phase_in  = ph;
      held_in   = held;
      lit_in    = lit;
      pad_in    = pad;
      offset_in = offset;
      outl_in   = outl;
      srcl_in   = srcl;
      emit      = 1'b0;
      run       = '0;
      n_wide      = '0;
      stride_wide = '0;
      fill_wide   = '0;
      outl_sub    = outl;
      spent_after = 1'b0;

      if (ph == PH_DONE) begin
         emit = 1'b0;
      end else if (outl == '0 || srcl == '0) begin
         // Nothing left to spend: empty finish result.
         emit = 1'b1;
         run.finished = 1'b1;
         phase_in = PH_DONE;
      end else begin
         srcl_in = srcl_dec;
         case (ph)
            PH_COUNT: begin
               held_in = src_byte;
               if (srcl_dec == '0) begin
                  emit = 1'b1;
                  run.finished = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               if (held != '0) begin
                  n_wide = {{(rle8d_pkg::COUNT_W-rle8d_pkg::BYTE_W){1'b0}}, held};
                  if (outl < n_wide) begin
                     n_wide = outl;
                  end
                  outl_sub  = outl - n_wide;
                  outl_in   = outl_sub;
                  offset_in = offset + n_wide;
                  spent_after = (outl_sub == '0) || (srcl_dec == '0);
                  emit = 1'b1;
                  run.fill_value = src_byte;
                  run.run_length = n_wide[rle8d_pkg::LEN_W-1:0];
                  run.finished   = spent_after;
                  phase_in = spent_after ? PH_DONE : PH_COUNT;
               end else if (src_byte > 8'd2) begin
                  n_wide = b_wide;
                  if (n_wide > srcl_dec) begin
                     n_wide = srcl_dec;
                  end
                  if (n_wide > outl) begin
                     n_wide = outl;
                  end
                  lit_in   = n_wide[rle8d_pkg::BYTE_W-1:0];
                  pad_in   = src_byte[0];
                  phase_in = PH_LITERAL;
               end else if (src_byte == 8'd0) begin
                  // End of line: pad the line out to its stride.
                  stride_wide = {{(rle8d_pkg::COUNT_W-rle8d_pkg::STRIDE_W){1'b0}},
                                 cfg.line_stride};
                  if (stride_wide > MAX_LINE) begin
                     stride_wide = MAX_LINE;
                  end
                  if (stride_wide > offset) begin
                     fill_wide = stride_wide - offset;
                  end
                  if (fill_wide > outl) begin
                     fill_wide = outl;
                  end
                  outl_sub  = outl - fill_wide;
                  outl_in   = outl_sub;
                  offset_in = '0;
                  spent_after = (outl_sub == '0) || (srcl_dec == '0);
                  emit = (fill_wide != '0) || spent_after;
                  run.run_length = fill_wide[rle8d_pkg::LEN_W-1:0];
                  run.finished   = spent_after;
                  phase_in = spent_after ? PH_DONE : PH_COUNT;
               end else if (src_byte == 8'd1) begin
                  // End of bitmap.
                  emit = 1'b1;
                  run.finished = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  // Delta escape: consumed, no pixels.
                  if (srcl_dec == '0) begin
                     emit = 1'b1;
                     run.finished = 1'b1;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_COUNT;
                  end
               end
            end
            PH_LITERAL: begin
               outl_sub  = outl - 1'b1;
               outl_in   = outl_sub;
               offset_in = offset + 1'b1;
               if (lit != '0) begin
                  lit_in = lit - 1'b1;
               end
               spent_after = (outl_sub == '0) || (srcl_dec == '0);
               emit = 1'b1;
               run.fill_value = src_byte;
               run.run_length = rle8d_pkg::LEN_W'(1);
               run.finished   = spent_after;
               if (spent_after) begin
                  phase_in = PH_DONE;
               end else if (lit_in == '0) begin
                  phase_in = pad ? PH_PAD : PH_COUNT;
               end
            end
            PH_PAD: begin
               pad_in = 1'b0;
               if (srcl_dec == '0) begin
                  emit = 1'b1;
                  run.finished = 1'b1;
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_COUNT;
               end
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_COUNT;
         held_ff   <= '0;
         lit_ff    <= '0;
         pad_ff    <= 1'b0;
         offset_ff <= '0;
         outl_ff   <= rle8d_pkg::OUT_TOTAL_RESET;
         srcl_ff   <= rle8d_pkg::SRC_TOTAL_RESET;
      end else if (byte_accept) begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         lit_ff    <= lit_in;
         pad_ff    <= pad_in;
         offset_ff <= offset_in;
         outl_ff   <= outl_in;
         srcl_ff   <= srcl_in;
      end
   end

   assign run_push = byte_accept && emit;
   assign run_data = run;

endmodule
`default_nettype wire

// ===== rtl/rle8d_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLE8 run decoder result queue
// Short register queue between the decoder and the result channel.
// ----------------------------------------------------------------------------
module rle8d_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rle8d_pkg::run_type push_data,
   output      logic               full,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      rle8d_pkg::run_type out_data
);

   rle8d_pkg::run_type                   entry_ff [rle8d_pkg::QUEUE_DEPTH];
   logic [rle8d_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [rle8d_pkg::QUEUE_CNT_W-1:0]    count_ff;
   logic                                 pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign full      = (count_ff == rle8d_pkg::QUEUE_CNT_W'(rle8d_pkg::QUEUE_DEPTH));
   assign out_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/bmp_rle8_run_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLE8 bitmap run decoder
// Turns a stream of run-length compressed 8-bit bitmap bytes into pixel runs.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Carries
//  -------  ---------  -----------------------------------------------------
//  req_     in         src_byte in tdata, start_image in tuser
//  rsp_     out        fill_value and run_length in tdata, finished in tlast
//  csr_     in         register index and write data (stride, totals)
//
// One compressed byte is taken per cycle while the queue has room; the run
// a byte causes is written into the queue. The per-byte decode step sets
// this rate. The decoder pushes into a two-entry queue, so a stalled result
// channel only holds off req_ once the queue is full. Reset is synchronous
// and clears the decoder state and the queue; registers return to their
// default values. Register writes are taken at any time, one per cycle.
//
module bmp_rle8_run_decoder_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input bytes
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [7:0]                          req_tdata,  // [7:0] src_byte
   input  wire logic                                req_tuser,  // [0] start_image
   // Result runs
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [7:0] fill_value, [22:8] run_length, [23] zero
   output      logic [23:0]                         rsp_tdata,
   output      logic                                rsp_tlast,  // finished
   // Register writes
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [rle8d_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rle8d_pkg::CSR_DATA_W-1:0]    csr_data
);

   rle8d_pkg::cfg_type   cfg_ff;
   rle8d_pkg::run_type   push_run, head_run;
   logic                 push, queue_full, byte_accept;

   // Register file: a write is taken in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_stride  <= rle8d_pkg::STRIDE_RESET;
         cfg_ff.output_total <= rle8d_pkg::OUT_TOTAL_RESET;
         cfg_ff.source_total <= rle8d_pkg::SRC_TOTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rle8d_pkg::CSR_LINE_STRIDE:
               cfg_ff.line_stride  <= csr_data[rle8d_pkg::STRIDE_W-1:0];
            rle8d_pkg::CSR_OUTPUT_TOTAL:
               cfg_ff.output_total <= csr_data[rle8d_pkg::COUNT_W-1:0];
            rle8d_pkg::CSR_SOURCE_TOTAL:
               cfg_ff.source_total <= csr_data[rle8d_pkg::COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A byte is taken whenever the queue has room for the run it may cause.
   assign req_tready  = !queue_full;
   assign byte_accept = req_tvalid && req_tready;

   rle8d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .byte_accept (byte_accept),
      .src_byte    (req_tdata),
      .start_image (req_tuser),
      .run_push    (push),
      .run_data    (push_run)
   );

   rle8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_run),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head_run)
   );

   assign rsp_tdata = {1'b0, head_run.run_length, head_run.fill_value};
   assign rsp_tlast = head_run.finished;

endmodule
`default_nettype wire

// ===== rtl/rle8d_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RLE8 run decoder port checker
// Watches the result channel of the decoder over time.
// ----------------------------------------------------------------------------
module rle8d_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tlast
);

   // A waiting result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // An empty run only ever ends decoding, and carries a zero value.
   a_empty_is_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[22:8] == 15'd0) |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("empty run without finish");

   // No run exceeds the longest line, and the pad bit stays clear.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:8] <= 15'd16384) && !rsp_tdata[23])
      else $error("run length out of range");

   // The queue is empty in the cycle after a reset edge.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind bmp_rle8_run_decoder_unit rle8d_checker u_rle8d_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
